// File: hw/rtl/btoe_pkg.sv
// ----------------------------------------------------------------------------
// btoe_pkg
// Shared types and constants of the bookmark table with oldest eviction.
// ----------------------------------------------------------------------------
package btoe_pkg;

    localparam int ENTRIES   = 128;
    localparam int KEY_WIDTH = 64;
    localparam int LINE_W    = 24;
    localparam int TIME_W    = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam logic [2:0] OP_OPEN    = 3'd0;
    localparam logic [2:0] OP_BACKUP  = 3'd1;
    localparam logic [2:0] OP_RESTORE = 3'd2;
    localparam logic [2:0] OP_DROP    = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_CREATED  = 3'd1;
    localparam logic [2:0] ST_EVICTED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_DISABLED = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [LINE_W-1:0]    line;
        logic [TIME_W-1:0]    stamp;
    } entry_t;

    typedef struct packed {
        logic             rot;
        logic             shift;
        logic             wr;
        logic [IDX_W-1:0] idx;
        entry_t           wdata;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_APPEND,
        S_FINISH
    } fsm_state_t;

endpackage

// File: hw/rtl/btoe_if.sv
// ----------------------------------------------------------------------------
// btoe_if
// Request and result channels of the bookmark table.
// ----------------------------------------------------------------------------
interface btoe_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [63:0] name_key;
    logic [23:0] line_value;
    logic [31:0] time_value;

    modport source (output valid, opcode, name_key, line_value, time_value, input ready);
    modport sink (input valid, opcode, name_key, line_value, time_value, output ready);
endinterface

interface btoe_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  entry_index;
    logic [23:0] line_out;
    logic        restore_valid;
    logic [7:0]  entry_count;

    modport source (output valid, status, entry_index, line_out, restore_valid, entry_count,
                    input ready);
    modport sink (input valid, status, entry_index, line_out, restore_valid, entry_count,
                  output ready);
endinterface

// File: hw/rtl/btoe_cell.sv
// ----------------------------------------------------------------------------
// btoe_cell
// One table slot: rotates with the ring, shifts down on delete, or is written.
// ----------------------------------------------------------------------------
module btoe_cell
    import btoe_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] pos,
    input  cell_ctrl_t       ctrl,
    input  entry_t           nb_in,
    output entry_t           ent
);

    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.rot)
        begin
            ent_next = nb_in;
        end
        else if (ctrl.shift && (pos >= ctrl.idx))
        begin
            ent_next = nb_in;
        end
        else if (ctrl.wr && (pos == ctrl.idx))
        begin
            ent_next = ctrl.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

// File: hw/rtl/btoe_ctrl.sv
// ----------------------------------------------------------------------------
// btoe_ctrl
// Sequencer: scans the ring for key and oldest entry, then edits the table.
// ----------------------------------------------------------------------------
module btoe_ctrl
    import btoe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    btoe_req_if.sink    in_ch,
    btoe_rsp_if.source  out_ch,
    input  entry_t      head,
    output cell_ctrl_t  cc
);

    fsm_state_t state_reg, state_next;

    logic                 en_reg;
    logic [2:0]           op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [LINE_W-1:0]    line_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     k_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     fidx_reg;
    logic [LINE_W-1:0]    fline_reg;
    logic [TIME_W-1:0]    ftime_reg;
    logic [IDX_W-1:0]     midx_reg;
    logic [LINE_W-1:0]    mline_reg;
    logic [TIME_W-1:0]    mtime_reg;
    logic                 evict_reg;
    logic [2:0]           rstat_reg;
    logic [IDX_W-1:0]     ridx_reg;
    logic [LINE_W-1:0]    rline_reg;
    logic                 rvalid_reg;

    logic                 ovalid_reg;
    logic [2:0]           ostat_reg;
    logic [IDX_W-1:0]     oidx_reg;
    logic [LINE_W-1:0]    oline_reg;
    logic                 orv_reg;
    logic [CNT_W-1:0]     ocnt_reg;

    logic accept;
    logic quick;
    logic out_free;
    logic full;
    logic in_range;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !ovalid_reg || out_ch.ready;
    assign full     = (cnt_reg == CNT_W'(ENTRIES));
    assign in_range = ({1'b0, k_reg} < cnt_reg);
    assign quick    = !en_reg || (in_ch.opcode >= OP_CLEAR)
                      || ((cnt_reg == '0) && (in_ch.opcode != OP_OPEN));

    assign in_ch.ready = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = quick ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (k_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if ((op_reg == OP_OPEN) && !found_reg)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_APPEND:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // cell controls
    always_comb
    begin
        cc = '0;
        unique case (state_reg)
            S_SCAN:
            begin
                cc.rot = 1'b1;
            end
            S_APPLY:
            begin
                if ((op_reg == OP_DROP) || ((op_reg == OP_OPEN) && !found_reg && full))
                begin
                    cc.shift = 1'b1;
                    cc.idx   = midx_reg;
                end
                else if ((op_reg == OP_BACKUP) && found_reg)
                begin
                    cc.wr          = 1'b1;
                    cc.idx         = fidx_reg;
                    cc.wdata.key   = key_reg;
                    cc.wdata.line  = line_reg;
                    cc.wdata.stamp = time_reg;
                end
            end
            S_APPEND:
            begin
                cc.wr          = 1'b1;
                cc.idx         = cnt_reg[IDX_W-1:0];
                cc.wdata.key   = key_reg;
                cc.wdata.line  = '0;
                cc.wdata.stamp = time_reg;
            end
            default:
            begin
                cc = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            en_reg     <= 1'b0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                en_reg <= cfg_wr_data;
            end
            if (accept && en_reg && (in_ch.opcode == OP_CLEAR))
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_APPLY)
            begin
                if ((op_reg == OP_DROP) || ((op_reg == OP_OPEN) && !found_reg && full))
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            else if (state_reg == S_APPEND)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if ((state_reg == S_FINISH) && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= in_ch.opcode;
            key_reg    <= in_ch.name_key[KEY_WIDTH-1:0];
            line_reg   <= in_ch.line_value;
            time_reg   <= in_ch.time_value;
            k_reg      <= '0;
            found_reg  <= 1'b0;
            evict_reg  <= 1'b0;
            ridx_reg   <= '0;
            rline_reg  <= '0;
            rvalid_reg <= 1'b0;
            if (!en_reg)
            begin
                rstat_reg <= ST_DISABLED;
            end
            else if (in_ch.opcode == OP_CLEAR)
            begin
                rstat_reg <= ST_FOUND;
            end
            else if (in_ch.opcode > OP_CLEAR)
            begin
                rstat_reg <= ST_NOTFOUND;
            end
            else if (cnt_reg == '0 && in_ch.opcode != OP_OPEN)
            begin
                rstat_reg <= ST_EMPTY;
            end
            else
            begin
                rstat_reg <= ST_NOTFOUND;
            end
        end
        if (state_reg == S_SCAN)
        begin
            k_reg <= k_reg + 1'b1;
            // head cell holds entry k during the rotation pass
            if (in_range && !found_reg && (head.key == key_reg))
            begin
                found_reg <= 1'b1;
                fidx_reg  <= k_reg;
                fline_reg <= head.line;
                ftime_reg <= head.stamp;
            end
            if (in_range && ((k_reg == '0) || (head.stamp < mtime_reg)))
            begin
                midx_reg  <= k_reg;
                mline_reg <= head.line;
                mtime_reg <= head.stamp;
            end
        end
        if (state_reg == S_APPLY)
        begin
            unique case (op_reg)
                OP_OPEN:
                begin
                    if (found_reg)
                    begin
                        rstat_reg  <= ST_FOUND;
                        ridx_reg   <= fidx_reg;
                        rline_reg  <= fline_reg;
                        rvalid_reg <= (fline_reg != '0) && (ftime_reg != '0);
                    end
                    else
                    begin
                        evict_reg <= full;
                    end
                end
                OP_BACKUP:
                begin
                    if (found_reg)
                    begin
                        rstat_reg  <= ST_FOUND;
                        ridx_reg   <= fidx_reg;
                        rline_reg  <= line_reg;
                        rvalid_reg <= (line_reg != '0) && (time_reg != '0);
                    end
                end
                OP_RESTORE:
                begin
                    if (found_reg)
                    begin
                        rstat_reg  <= ST_FOUND;
                        ridx_reg   <= fidx_reg;
                        rline_reg  <= fline_reg;
                        rvalid_reg <= (fline_reg != '0) && (ftime_reg != '0);
                    end
                end
                OP_DROP:
                begin
                    rstat_reg <= ST_FOUND;
                    ridx_reg  <= midx_reg;
                    rline_reg <= mline_reg;
                end
                default:
                begin
                    rstat_reg <= ST_NOTFOUND;
                end
            endcase
        end
        if (state_reg == S_APPEND)
        begin
            rstat_reg <= evict_reg ? ST_EVICTED : ST_CREATED;
            ridx_reg  <= cnt_reg[IDX_W-1:0];
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            ostat_reg <= rstat_reg;
            oidx_reg  <= ridx_reg;
            oline_reg <= rline_reg;
            orv_reg   <= rvalid_reg;
            ocnt_reg  <= cnt_reg;
        end
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.status        = ostat_reg;
    assign out_ch.entry_index   = oidx_reg;
    assign out_ch.line_out      = oline_reg;
    assign out_ch.restore_valid = orv_reg;
    assign out_ch.entry_count   = ocnt_reg;

endmodule

// File: hw/rtl/bookmark_table_oldest_eviction_unit.sv
// ----------------------------------------------------------------------------
// bookmark_table_oldest_eviction_unit
// Compacted bookmark table with oldest-timestamp eviction.
// ----------------------------------------------------------------------------
// The table is a ring of 128 slot cells. Every operation except clear, a
// disabled table, an unused opcode or an empty-table query makes one full
// rotation pass of the ring that looks for the key and the oldest entry at
// the head cell, then edits the cells in the apply state and, for an open
// that creates an entry, in the append state. Deletion shifts all later
// cells down together in the apply state. One item is worked on at a time;
// the next is taken while the previous result still waits in the output
// register.
module bookmark_table_oldest_eviction_unit
    import btoe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    btoe_req_if.sink   in_ch,
    btoe_rsp_if.source out_ch
);

    cell_ctrl_t cc;
    entry_t     ents [ENTRIES];

    btoe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .head        (ents[0]),
        .cc          (cc)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        btoe_cell u_cell (
            .clk   (clk),
            .pos   (IDX_W'(i)),
            .ctrl  (cc),
            .nb_in (ents[(i + 1) % ENTRIES]),
            .ent   (ents[i])
        );
    end

endmodule
